// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/psbp_pkg.sv -----
// Package for the packet sequence block placer: codes, reset values, types.
// No dependencies.
package psbp_pkg;

   localparam int DEFAULT_SEQ_BITS   = 48;
   localparam int DEFAULT_MAX_BLOCKS = 256;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOTS_PER_BLOCK = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLOCK_COUNT     = 4'd1;

   localparam logic [15:0] PPB_RESET         = 16'd1024;
   localparam logic [8:0]  BLOCK_COUNT_RESET = 9'd8;
   localparam int          START_SEQ         = 2048;

   localparam logic [1:0] KIND_CLOSE   = 2'd0;
   localparam logic [1:0] KIND_PLACE   = 2'd1;
   localparam logic [1:0] KIND_DISCARD = 2'd2;

   localparam logic [16:0] BLOCK_CNT_MAX = 17'h1FFFF;
   localparam logic [47:0] TOTAL_CNT_MAX = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  block_index;
      logic [15:0] slot;
      logic [15:0] fill_start;
      logic [47:0] block_first_seq;
      logic [16:0] block_packet_count;
      logic [16:0] block_drop_count;
      logic [47:0] total_packet_count;
      logic [47:0] total_drop_count;
      logic        new_observation;
      logic        last;
   } rsp_type;

endpackage

// ----- rtl/packet_sequence_block_placer_core.sv -----
// Top level of the packet sequence block placer: sequencer, state, config.
// Depends on psbp_pkg, psbp_sub_unit and psbp_rsp_stage.
//
//   channel | ports                         | direction | transaction
//   --------+-------------------------------+-----------+----------------------------
//   req     | req_valid/req_ready/req_*     | in        | one packet sequence number
//   rsp     | rsp_valid/rsp_ready/rsp_*     | out       | close, placed or discard record
//   csr     | csr_valid/csr_ready/csr_*     | in        | one register write
//
// Steps: a packet inside the open block runs accept, diff, offset and place; a
// discard runs accept, diff and discard. A packet that opens the first block runs
// accept, diff, offset, remainder, base and place, one that closes the open block
// adds a close step after offset. The restoring remainder of seq by the block
// length runs one bit per cycle on the shared subtractor, which also forms the
// sequence difference, block offset and base. req_ready is high only while the
// sequencer is idle. Reset is synchronous; no clearing pass. The result register
// lets a new transaction be taken while the last result waits; a stalled rsp side
// holds the sequencer only where it must load a result. csr_ready is always high.
module packet_sequence_block_placer_core import psbp_pkg::*; #(
   parameter int SEQ_BITS   = DEFAULT_SEQ_BITS,
   parameter int MAX_BLOCKS = DEFAULT_MAX_BLOCKS
) (
   input  logic                      clock,
   input  logic                      reset,
   // request
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [47:0]               req_packet_seq,
   // response
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_kind,
   output logic [7:0]                rsp_block_index,
   output logic [15:0]               rsp_slot,
   output logic [15:0]               rsp_fill_start,
   output logic [47:0]               rsp_block_first_seq,
   output logic [16:0]               rsp_block_packet_count,
   output logic [16:0]               rsp_block_drop_count,
   output logic [47:0]               rsp_total_packet_count,
   output logic [47:0]               rsp_total_drop_count,
   output logic                      rsp_new_observation,
   output logic                      rsp_last,
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int CB_W   = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = $clog2(SEQ_BITS);
   localparam int SUB_W  = (SEQ_BITS > 17) ? SEQ_BITS : 17;
   localparam int NB_W   = (CB_W + 1 > 9) ? CB_W + 1 : 9;
   localparam int EXT_W  = SEQ_BITS + 48;
   localparam int BIX_W  = CB_W + 8;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_DIFF   = 8'b0000_0010,
      ST_OFFSET = 8'b0000_0100,
      ST_CLOSE  = 8'b0000_1000,
      ST_DIV    = 8'b0001_0000,
      ST_BASE   = 8'b0010_0000,
      ST_PLACE  = 8'b0100_0000,
      ST_DISC   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [15:0] ppb_ff, ppb_in;
   logic [8:0]  bcount_ff, bcount_in;

   // placement state
   logic [SEQ_BITS-1:0] prev_ff, prev_in;
   logic                open_ff, open_in;
   logic [CB_W-1:0]     cur_ff, cur_in;
   logic [SEQ_BITS-1:0] base_ff, base_in;
   logic [15:0]         next_slot_ff, next_slot_in;
   logic [16:0]         bp_ff, bp_in;
   logic [16:0]         bd_ff, bd_in;
   logic [47:0]         tp_ff, tp_in;
   logic [47:0]         td_ff, td_in;

   // per-transaction working registers
   logic [SEQ_BITS-1:0] seq_ff, seq_in;
   logic                force_ff, force_in;
   logic [15:0]         rem_ff, rem_in;
   logic [CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [15:0]         offset_ff, offset_in;

   // shared subtractor
   logic [SUB_W-1:0] sub_a, sub_b, sub_diff;
   logic             sub_borrow;

   // output stage
   logic    load, out_free;
   rsp_type load_data, rsp_data;

   logic [15:0]         ppb_eff;
   logic [8:0]          bcount_eff;
   logic [NB_W-1:0]     nblk;
   logic                wrap;
   logic [EXT_W-1:0]    seq_ext, base_ext;
   logic [BIX_W-1:0]    bix_ext;
   logic [16:0]         div_shift;
   logic [SEQ_BITS-1:0] sub_low;
   logic                near_gap;

   // placement arithmetic
   logic        slot_ahead;
   logic [15:0] fill, drops;
   logic [16:0] inc;
   logic [17:0] bd_sum, bp_sum;
   logic [48:0] td_sum, tp_sum;
   logic [16:0] bd_new, bp_new;
   logic [47:0] td_new, tp_new;

   psbp_sub_unit #(.WIDTH(SUB_W)) u_sub (
      .sub_a      (sub_a),
      .sub_b      (sub_b),
      .sub_diff   (sub_diff),
      .sub_borrow (sub_borrow)
   );

   psbp_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .load_data (load_data),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // zero in a register means one
   assign ppb_eff    = (ppb_ff == 16'd0) ? 16'd1 : ppb_ff;
   assign bcount_eff = (bcount_ff == 9'd0) ? 9'd1 : bcount_ff;
   assign nblk       = (NB_W'(bcount_eff) > NB_W'(MAX_BLOCKS)) ? NB_W'(MAX_BLOCKS)
                                                               : NB_W'(bcount_eff);
   assign wrap       = (NB_W'(cur_ff) + NB_W'(1)) >= nblk;

   // field width adaption between SEQ_BITS and the 48-bit ports
   assign seq_ext  = EXT_W'(req_packet_seq);
   assign base_ext = EXT_W'(base_ff);
   assign bix_ext  = BIX_W'(cur_ff);

   assign div_shift = {rem_ff, seq_ff[bit_cnt_ff]};
   assign sub_low   = sub_diff[SEQ_BITS-1:0];
   // difference within 128 behind: bits above 6 all ones
   assign near_gap  = &sub_low[SEQ_BITS-1:7];

   // shared subtractor operand select
   always_comb begin
      unique case (state_ff)
         ST_DIFF: begin
            sub_a = SUB_W'(seq_ff);
            sub_b = SUB_W'(prev_ff);
         end
         ST_OFFSET: begin
            sub_a = SUB_W'(seq_ff);
            sub_b = SUB_W'(base_ff);
         end
         ST_DIV: begin
            sub_a = SUB_W'(div_shift);
            sub_b = SUB_W'(ppb_eff);
         end
         ST_BASE: begin
            sub_a = SUB_W'(seq_ff);
            sub_b = SUB_W'(rem_ff);
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
         end
      endcase
   end

   // slot, zero-fill range and saturating counts of a placed packet
   always_comb begin
      slot_ahead = offset_ff >= next_slot_ff;
      fill       = slot_ahead ? next_slot_ff : offset_ff;
      drops      = slot_ahead ? (offset_ff - next_slot_ff) : 16'd0;
      inc        = 17'(drops) + 17'd1;
      bd_sum     = 18'(bd_ff) + 18'(drops);
      bp_sum     = 18'(bp_ff) + 18'(inc);
      td_sum     = 49'(td_ff) + 49'(drops);
      tp_sum     = 49'(tp_ff) + 49'(inc);
      bd_new     = (bd_sum > 18'(BLOCK_CNT_MAX)) ? BLOCK_CNT_MAX : bd_sum[16:0];
      bp_new     = (bp_sum > 18'(BLOCK_CNT_MAX)) ? BLOCK_CNT_MAX : bp_sum[16:0];
      td_new     = (td_sum > 49'(TOTAL_CNT_MAX)) ? TOTAL_CNT_MAX : td_sum[47:0];
      tp_new     = (tp_sum > 49'(TOTAL_CNT_MAX)) ? TOTAL_CNT_MAX : tp_sum[47:0];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ppb_in       = ppb_ff;
      bcount_in    = bcount_ff;
      prev_in      = prev_ff;
      open_in      = open_ff;
      cur_in       = cur_ff;
      base_in      = base_ff;
      next_slot_in = next_slot_ff;
      bp_in        = bp_ff;
      bd_in        = bd_ff;
      tp_in        = tp_ff;
      td_in        = td_ff;
      seq_in       = seq_ff;
      force_in     = force_ff;
      rem_in       = rem_ff;
      bit_cnt_in   = bit_cnt_ff;
      offset_in    = offset_ff;
      load         = 1'b0;

      // common record fields; kind-specific ones set below
      load_data.kind               = KIND_DISCARD;
      load_data.block_index        = bix_ext[7:0];
      load_data.slot               = 16'd0;
      load_data.fill_start         = 16'd0;
      load_data.block_first_seq    = base_ext[47:0];
      load_data.block_packet_count = bp_ff;
      load_data.block_drop_count   = bd_ff;
      load_data.total_packet_count = tp_ff;
      load_data.total_drop_count   = td_ff;
      load_data.new_observation    = 1'b0;
      load_data.last               = 1'b1;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_SLOTS_PER_BLOCK: ppb_in    = csr_data;
            CSR_BLOCK_COUNT:     bcount_in = csr_data[8:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               seq_in   = seq_ext[SEQ_BITS-1:0];
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            // behind the previous packet: far means new observation
            force_in = open_ff && sub_low[SEQ_BITS-1] && !near_gap;
            if (open_ff && sub_low[SEQ_BITS-1] && near_gap) begin
               state_in = ST_DISC;
            end else begin
               state_in = ST_OFFSET;
            end
         end
         ST_OFFSET: begin
            if (!open_ff || force_ff || (sub_low >= SEQ_BITS'(ppb_eff))) begin
               rem_in     = 16'd0;
               bit_cnt_in = CNT_W'(SEQ_BITS - 1);
               if (open_ff) begin
                  state_in = ST_CLOSE;
               end else begin
                  cur_in   = '0;
                  state_in = ST_DIV;
               end
            end else begin
               offset_in = sub_low[15:0];
               state_in  = ST_PLACE;
            end
         end
         ST_CLOSE: begin
            if (out_free) begin
               load                      = 1'b1;
               load_data.kind            = KIND_CLOSE;
               load_data.new_observation = force_ff;
               load_data.last            = 1'b0;
               cur_in                    = wrap ? '0 : cur_ff + CB_W'(1);
               state_in                  = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring remainder, one sequence bit per cycle
            rem_in = sub_borrow ? div_shift[15:0] : sub_diff[15:0];
            if (bit_cnt_ff == '0) begin
               state_in = ST_BASE;
            end else begin
               bit_cnt_in = bit_cnt_ff - CNT_W'(1);
            end
         end
         ST_BASE: begin
            base_in      = sub_low;
            offset_in    = rem_ff;
            next_slot_in = 16'd0;
            bp_in        = 17'd0;
            bd_in        = 17'd0;
            if (force_ff) begin
               tp_in = 48'd0;
               td_in = 48'd0;
            end
            open_in  = 1'b1;
            state_in = ST_PLACE;
         end
         ST_PLACE: begin
            load_data.kind               = KIND_PLACE;
            load_data.slot               = offset_ff;
            load_data.fill_start         = fill;
            load_data.block_packet_count = bp_new;
            load_data.block_drop_count   = bd_new;
            load_data.total_packet_count = tp_new;
            load_data.total_drop_count   = td_new;
            load_data.new_observation    = force_ff;
            if (out_free) begin
               load         = 1'b1;
               bp_in        = bp_new;
               bd_in        = bd_new;
               tp_in        = tp_new;
               td_in        = td_new;
               next_slot_in = offset_ff + 16'd1;
               prev_in      = seq_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_DISC: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ppb_ff       <= PPB_RESET;
         bcount_ff    <= BLOCK_COUNT_RESET;
         prev_ff      <= SEQ_BITS'(START_SEQ);
         open_ff      <= 1'b0;
         cur_ff       <= '0;
         base_ff      <= '0;
         next_slot_ff <= 16'd0;
         bp_ff        <= 17'd0;
         bd_ff        <= 17'd0;
         tp_ff        <= 48'd0;
         td_ff        <= 48'd0;
         force_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ppb_ff       <= ppb_in;
         bcount_ff    <= bcount_in;
         prev_ff      <= prev_in;
         open_ff      <= open_in;
         cur_ff       <= cur_in;
         base_ff      <= base_in;
         next_slot_ff <= next_slot_in;
         bp_ff        <= bp_in;
         bd_ff        <= bd_in;
         tp_ff        <= tp_in;
         td_ff        <= td_in;
         force_ff     <= force_in;
      end
      seq_ff     <= seq_in;
      rem_ff     <= rem_in;
      bit_cnt_ff <= bit_cnt_in;
      offset_ff  <= offset_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_kind               = rsp_data.kind;
   assign rsp_block_index        = rsp_data.block_index;
   assign rsp_slot               = rsp_data.slot;
   assign rsp_fill_start         = rsp_data.fill_start;
   assign rsp_block_first_seq    = rsp_data.block_first_seq;
   assign rsp_block_packet_count = rsp_data.block_packet_count;
   assign rsp_block_drop_count   = rsp_data.block_drop_count;
   assign rsp_total_packet_count = rsp_data.total_packet_count;
   assign rsp_total_drop_count   = rsp_data.total_drop_count;
   assign rsp_new_observation    = rsp_data.new_observation;
   assign rsp_last               = rsp_data.last;

endmodule

// ----- rtl/psbp_sub_unit.sv -----
// Shared subtractor: difference and borrow of two unsigned operands.
// No dependencies.
module psbp_sub_unit #(
   parameter int WIDTH = 48
) (
   input  logic [WIDTH-1:0] sub_a,
   input  logic [WIDTH-1:0] sub_b,
   output logic [WIDTH-1:0] sub_diff,
   output logic             sub_borrow
);

   logic [WIDTH:0] full;

   assign full       = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_diff   = full[WIDTH-1:0];
   assign sub_borrow = full[WIDTH];

endmodule

// ----- rtl/psbp_rsp_stage.sv -----
// Result output register with valid/ready handshake.
// Depends on psbp_pkg (rsp_type).
module psbp_rsp_stage import psbp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // slot is free when empty or being drained this cycle
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load && free) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- rtl/psbp_checker.sv -----
// Port-level checker for the packet sequence block placer, bound to the top.
// Depends on psbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module psbp_checker import psbp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_block_index,
   input logic [15:0] rsp_slot,
   input logic [15:0] rsp_fill_start,
   input logic [47:0] rsp_block_first_seq,
   input logic [16:0] rsp_block_packet_count,
   input logic [16:0] rsp_block_drop_count,
   input logic [47:0] rsp_total_packet_count,
   input logic [47:0] rsp_total_drop_count,
   input logic        rsp_new_observation,
   input logic        rsp_last
);

   rsp_type rsp_word;
   logic    rsp_stall;
   logic    is_close, on_place, off_place, on_disc;
   logic    slots_zero, counts_ok;

   assign rsp_word = {rsp_kind, rsp_block_index, rsp_slot, rsp_fill_start,
                      rsp_block_first_seq, rsp_block_packet_count, rsp_block_drop_count,
                      rsp_total_packet_count, rsp_total_drop_count, rsp_new_observation,
                      rsp_last};

   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign is_close   = (rsp_kind == KIND_CLOSE);
   assign on_place   = rsp_valid && (rsp_kind == KIND_PLACE);
   assign off_place  = rsp_valid && (rsp_kind != KIND_PLACE);
   assign on_disc    = rsp_valid && (rsp_kind == KIND_DISCARD);
   assign slots_zero = (rsp_slot == 16'd0) && (rsp_fill_start == 16'd0);
   assign counts_ok  = (rsp_fill_start <= rsp_slot) &&
                       ((rsp_block_drop_count < rsp_block_packet_count) ||
                        (rsp_block_packet_count == BLOCK_CNT_MAX));

   // stalled result holds
   `ASSERT_NEXT(a_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word), "rsp not held")

   // only a close record is followed by another record of the same packet
   `ASSERT_IMPLY(a_last_kind, clock, reset, rsp_valid, is_close == !rsp_last, "last flag wrong")

   `ASSERT_IMPLY(a_slot_zero, clock, reset, off_place, slots_zero, "slot outside placed")

   `ASSERT_IMPLY(a_place_counts, clock, reset, on_place, counts_ok, "placed counts wrong")

   `ASSERT_IMPLY(a_disc_obs, clock, reset, on_disc, !rsp_new_observation, "discard flagged new")

endmodule

bind packet_sequence_block_placer_core psbp_checker u_psbp_checker (.*);

// ----- tb/psbp_placement_monitor.sv -----
// Placement monitor: watches the request, response and register channels of the block
// placer, predicts every record from its own model of the ring state and compares.
// Depends on psbp_pkg.
module psbp_placement_monitor import psbp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [47:0]               req_packet_seq,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [1:0]                rsp_kind,
   input  logic [7:0]                rsp_block_index,
   input  logic [15:0]               rsp_slot,
   input  logic [15:0]               rsp_fill_start,
   input  logic [47:0]               rsp_block_first_seq,
   input  logic [16:0]               rsp_block_packet_count,
   input  logic [16:0]               rsp_block_drop_count,
   input  logic [47:0]               rsp_total_packet_count,
   input  logic [47:0]               rsp_total_drop_count,
   input  logic                      rsp_new_observation,
   input  logic                      rsp_last,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                        fail_count,
   output int                        pending,
   output int                        records_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [47:0] RESTART_GAP = 48'd128;

   // register copies
   logic [15:0] ppb_cfg;
   logic [8:0]  blocks_cfg;

   // ring state
   logic [47:0] last_seq;
   logic        block_live;
   logic [8:0]  cur_block;
   logic [47:0] base_seq;
   logic [16:0] next_slot;
   logic [16:0] blk_packets;
   logic [16:0] blk_drops;
   logic [47:0] tot_packets;
   logic [47:0] tot_drops;

   rsp_type due_records[$];

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] lim);
      logic [63:0] sum;
      sum = a + b;
      return (sum > lim) ? lim : sum;
   endfunction

   // Snapshot of the current ring state as one record.
   function automatic rsp_type record_of(input logic [1:0] kind, input logic [15:0] slot,
                                         input logic [15:0] fill, input logic restart,
                                         input logic fin);
      rsp_type r;
      r.kind               = kind;
      r.block_index        = cur_block[7:0];
      r.slot               = slot;
      r.fill_start         = fill;
      r.block_first_seq    = base_seq;
      r.block_packet_count = blk_packets;
      r.block_drop_count   = blk_drops;
      r.total_packet_count = tot_packets;
      r.total_drop_count   = tot_drops;
      r.new_observation    = restart;
      r.last               = fin;
      return r;
   endfunction

   function automatic void place_packet(input logic [47:0] seq);
      logic [47:0] diff;
      logic [47:0] mag;
      logic [47:0] offset;
      logic [16:0] ppb;
      logic [16:0] slot;
      logic [16:0] fill;
      logic [16:0] drops;
      logic        restart;
      int          nblk;
      restart = 1'b0;
      ppb  = (ppb_cfg == 16'd0) ? 17'd1 : {1'b0, ppb_cfg};
      nblk = (blocks_cfg == 9'd0) ? 1 : int'(blocks_cfg);
      if (nblk > DEFAULT_MAX_BLOCKS) nblk = DEFAULT_MAX_BLOCKS;

      // signed distance to the previous packet, only while a block is open
      diff = seq - last_seq;
      if (block_live && diff[47]) begin
         mag = -diff;
         if (mag > RESTART_GAP) begin
            restart = 1'b1;
         end else begin
            due_records.push_back(record_of(KIND_DISCARD, 16'd0, 16'd0, 1'b0, 1'b1));
            return;
         end
      end

      offset = seq - base_seq;
      if (!block_live || restart || offset >= ppb) begin
         if (block_live) begin
            due_records.push_back(record_of(KIND_CLOSE, 16'd0, 16'd0, restart, 1'b0));
            cur_block = cur_block + 9'd1;
            if (cur_block >= nblk) cur_block = 9'd0;
         end else begin
            cur_block = 9'd0;
         end
         blk_packets = '0;
         blk_drops   = '0;
         if (restart) begin
            tot_packets = '0;
            tot_drops   = '0;
         end
         block_live = 1'b1;
         next_slot  = '0;
         base_seq   = seq - (seq % ppb);
         offset     = seq - base_seq;
      end

      slot = offset[16:0];
      if (slot >= next_slot) begin
         fill  = next_slot;
         drops = slot - next_slot;
      end else begin
         fill  = slot;      // duplicate or rewrite: nothing to zero
         drops = '0;
      end
      blk_drops   = 17'(sat_add(blk_drops, drops, BLOCK_CNT_MAX));
      blk_packets = 17'(sat_add(blk_packets, drops + 17'd1, BLOCK_CNT_MAX));
      tot_drops   = 48'(sat_add(tot_drops, drops, TOTAL_CNT_MAX));
      tot_packets = 48'(sat_add(tot_packets, drops + 17'd1, TOTAL_CNT_MAX));
      next_slot   = slot + 17'd1;
      last_seq    = seq;
      due_records.push_back(record_of(KIND_PLACE, slot[15:0], fill[15:0], restart, 1'b1));
   endfunction

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         ppb_cfg     = PPB_RESET;
         blocks_cfg  = BLOCK_COUNT_RESET;
         last_seq    = 48'(START_SEQ);
         block_live  = 1'b0;
         cur_block   = '0;
         base_seq    = '0;
         next_slot   = '0;
         blk_packets = '0;
         blk_drops   = '0;
         tot_packets = '0;
         tot_drops   = '0;
         due_records.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SLOTS_PER_BLOCK: ppb_cfg = csr_data;
               CSR_BLOCK_COUNT:     blocks_cfg = csr_data[8:0];
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            got = {rsp_kind, rsp_block_index, rsp_slot, rsp_fill_start, rsp_block_first_seq,
                   rsp_block_packet_count, rsp_block_drop_count, rsp_total_packet_count,
                   rsp_total_drop_count, rsp_new_observation, rsp_last};
            if (due_records.size() == 0) begin
               $display("%0t: unexpected record, expected none, got kind %0d block %0d",
                        $time, got.kind, got.block_index);
               fail_count++;
            end else begin
               want = due_records.pop_front();
               compare_field("kind", want.kind, got.kind);
               compare_field("block_index", want.block_index, got.block_index);
               compare_field("slot", want.slot, got.slot);
               compare_field("fill_start", want.fill_start, got.fill_start);
               compare_field("block_first_seq", want.block_first_seq, got.block_first_seq);
               compare_field("block_packet_count", want.block_packet_count,
                             got.block_packet_count);
               compare_field("block_drop_count", want.block_drop_count,
                             got.block_drop_count);
               compare_field("total_packet_count", want.total_packet_count,
                             got.total_packet_count);
               compare_field("total_drop_count", want.total_drop_count,
                             got.total_drop_count);
               compare_field("new_observation", want.new_observation, got.new_observation);
               compare_field("last", want.last, got.last);
            end
            records_checked++;
         end

         if (req_valid && req_ready) place_packet(req_packet_seq);
      end
      pending = due_records.size();
   end

endmodule

// ----- tb/tb.sv -----
// Top of the block placer regression: clock, reset, stimulus, idling and verdict.
// Depends on psbp_pkg, packet_sequence_block_placer_core and psbp_placement_monitor.
module tb;
   import psbp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Cycles without any transaction before the run is declared hung. An opening
   // packet is the slowest, and this is many times its length.
   localparam int STALL_LIMIT = 4000;
   // Settle time after the last record before the verdict or a register write.
   localparam int TAIL_CYCLES = 64;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PER_PHASE = 166;
   localparam int IDLE_PERCENT = 13;
   // Register index with no register behind it; writes there must be ignored.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 4'd15;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Every block input starts at a known value.
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [47:0]               req_packet_seq = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [1:0]                rsp_kind;
   logic [7:0]                rsp_block_index;
   logic [15:0]               rsp_slot;
   logic [15:0]               rsp_fill_start;
   logic [47:0]               rsp_block_first_seq;
   logic [16:0]               rsp_block_packet_count;
   logic [16:0]               rsp_block_drop_count;
   logic [47:0]               rsp_total_packet_count;
   logic [47:0]               rsp_total_drop_count;
   logic                      rsp_new_observation;
   logic                      rsp_last;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   int fail_count;
   int pending;
   int records_checked;

   // Stimulus bookkeeping.
   logic        calm = 1'b0;      // high: neither side idles
   logic [47:0] cursor;           // last sequence number the block should keep
   int          cur_ppb;          // packets per block as last written
   int          packets_sent = 0;
   int          settings_used = 1;
   int          stall_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   packet_sequence_block_placer_core u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_packet_seq         (req_packet_seq),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_kind               (rsp_kind),
      .rsp_block_index        (rsp_block_index),
      .rsp_slot               (rsp_slot),
      .rsp_fill_start         (rsp_fill_start),
      .rsp_block_first_seq    (rsp_block_first_seq),
      .rsp_block_packet_count (rsp_block_packet_count),
      .rsp_block_drop_count   (rsp_block_drop_count),
      .rsp_total_packet_count (rsp_total_packet_count),
      .rsp_total_drop_count   (rsp_total_drop_count),
      .rsp_new_observation    (rsp_new_observation),
      .rsp_last               (rsp_last),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   psbp_placement_monitor u_monitor (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_packet_seq         (req_packet_seq),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_kind               (rsp_kind),
      .rsp_block_index        (rsp_block_index),
      .rsp_slot               (rsp_slot),
      .rsp_fill_start         (rsp_fill_start),
      .rsp_block_first_seq    (rsp_block_first_seq),
      .rsp_block_packet_count (rsp_block_packet_count),
      .rsp_block_drop_count   (rsp_block_drop_count),
      .rsp_total_packet_count (rsp_total_packet_count),
      .rsp_total_drop_count   (rsp_total_drop_count),
      .rsp_new_observation    (rsp_new_observation),
      .rsp_last               (rsp_last),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .fail_count             (fail_count),
      .pending                (pending),
      .records_checked        (records_checked)
   );

   // Result side back-pressure: ready drops in about 13% of cycles, never while calm.
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Watchdog: any accepted transaction on any channel restarts the count.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("packet_sequence_block_placer_core regression: fail");
            $finish;
         end
      end
   end

   // One packet transaction. Called and returns at a rising edge; valid stays high on
   // return so back-to-back packets keep it up without a second assignment.
   task automatic send_packet(input logic [47:0] seq);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_packet_seq <= seq;
      // handshake is judged at the falling edge, taken at the next rising edge
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      packets_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stop sending and wait until every predicted record has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Switch both registers with the block idle.
   task automatic set_geometry(input logic [15:0] ppb, input logic [15:0] blocks);
      drain();
      write_reg(CSR_SLOTS_PER_BLOCK, ppb);
      write_reg(CSR_BLOCK_COUNT, blocks);
      cur_ppb = ppb;
      settings_used++;
   endtask

   // Mostly in-order traffic with random content; the rest is reordering,
   // duplicates, restarts, block skips, wrap-around and pure noise.
   task automatic random_packet();
      int          pick;
      int          span;
      logic [47:0] seq;
      logic [63:0] wide;
      logic        keep;
      span = (cur_ppb == 0) ? 1 : cur_ppb;
      pick = $urandom_range(99);
      keep = 1'b1;
      if (pick < 45) begin
         seq = cursor + 48'd1;
      end else if (pick < 57) begin
         seq = cursor + 48'($urandom_range(2, 9));       // gap: drops to fill
      end else if (pick < 65) begin
         seq = cursor;                                   // duplicate
      end else if (pick < 74) begin
         seq  = cursor - 48'($urandom_range(1, 128));    // slightly late: discarded
         keep = 1'b0;
      end else if (pick < 80) begin
         seq = cursor - 48'($urandom_range(129, 3000));  // far behind: restart
      end else if (pick < 90) begin
         seq = cursor + 48'(span * $urandom_range(1, 3)) - 48'($urandom_range(0, 2));
      end else if (pick < 95) begin
         wide = {$urandom, $urandom};
         seq  = wide[47:0];
      end else begin
         seq = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 2 * span));
      end
      if (keep) cursor = seq;
      send_packet(seq);
   endtask

   task automatic random_run(input int count);
      repeat (count) random_packet();
   endtask

   initial begin : stimulus
      logic [15:0] rand_blocks;
      cur_ppb = PPB_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, reset geometry: 1024 slots, 8 blocks.
      send_packet(48'd2000);               // behind start value, but no block open yet
      send_packet(48'd2000);               // duplicate is placed again
      send_packet(48'd2001);
      send_packet(48'd1990);               // slightly late: discard
      send_packet(48'd1873);               // exactly 128 behind: still a discard
      send_packet(48'd1872);               // 129 behind: new observation
      send_packet(48'd1873);
      send_packet(48'd4949);               // skips whole blocks, drops to block start
      send_packet(48'h8000_0000_1355);     // half the sequence space away: restart
      send_packet(48'd4948);               // just under half ahead: plain crossing
      send_packet(48'hFFFF_FFFF_FFFF);     // far behind: restart at the top
      send_packet(48'd0);                  // wraps through zero into a new block
      send_packet(48'd1023);               // last slot, long zero-fill
      send_packet(48'd1024);
      send_packet(48'd2047);
      send_packet(48'd2048);
      send_packet(48'd2048);
      cursor = 48'd2048;
      random_run(RANDOM_PER_PHASE);

      // Smallest geometry: every new sequence number closes a block.
      set_geometry(16'd1, 16'd1);
      write_reg(CSR_SPARE, 16'($urandom));
      random_run(RANDOM_PER_PHASE);

      // Zero values act as one.
      set_geometry(16'd0, 16'd0);
      random_run(RANDOM_PER_PHASE);

      // Largest geometry, with a stretch where neither side idles.
      set_geometry(16'hFFFF, 16'd256);
      calm <= 1'b1;
      random_run(RANDOM_PER_PHASE);

      // Block count above the ring limit, upper data bits set; then shrink the
      // ring below the current block so it wraps.
      drain();
      calm <= 1'b0;
      set_geometry(16'd7, {7'h7F, 9'd511});
      random_run(RANDOM_PER_PHASE);
      set_geometry(16'd16, 16'd3);
      random_run(RANDOM_PER_PHASE);
      set_geometry(16'd1024, 16'd257);
      random_run(RANDOM_PER_PHASE);

      rand_blocks = 16'($urandom);
      set_geometry(16'($urandom_range(2, 300)), rand_blocks);
      random_run(RANDOM_PER_PHASE);

      // All done: wait for the tail and give the verdict.
      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("covered %0d packets over %0d register settings, %0d records compared",
               packets_sent, settings_used, records_checked);
      if (fail_count == 0) begin
         $display("packet_sequence_block_placer_core regression: pass");
      end else begin
         $display("packet_sequence_block_placer_core regression: fail");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/psbp_pkg.sv
rtl/psbp_sub_unit.sv
rtl/psbp_rsp_stage.sv
rtl/packet_sequence_block_placer_core.sv
rtl/psbp_checker.sv
tb/psbp_placement_monitor.sv
tb/tb.sv
